// ===== sv/txcon_pkg.sv =====
// Package for the text console character engine: request and response beat
// types, character codes, controller states and controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package txcon_pkg;

   // Default screen geometry.
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // Attribute byte after reset: white on black.
   localparam logic [7:0] ATTR_RESET = 8'h0F;

   // Character codes that put-char interprets.
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LAST  = 8'h7F;

   // Operation codes.
   typedef enum logic [1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_SET   = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   // One request beat.
   typedef struct packed {
      func_type    func;
      logic [7:0]  char_code;
      logic [6:0]  set_col;
      logic [4:0]  set_row;
      logic [10:0] read_address;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic [10:0] cursor_location;
      logic [15:0] read_data;
      logic        scrolled;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_RESPOND,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_FILL
   } state_type;

   // Source of the screen memory read address.
   typedef enum logic {
      RD_REQ,
      RD_SCROLL
   } rd_src_type;

   // Source of the screen memory write address and data.
   typedef enum logic [1:0] {
      WR_PUT,
      WR_COPY,
      WR_BLANK
   } wr_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       put_step;
      logic       set_cursor;
      logic       home;
      logic       ptr_zero;
      logic       ptr_inc;
      logic       rd_en;
      rd_src_type rd_src;
      logic       wr_en;
      wr_src_type wr_src;
      logic       respond;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type func;
      logic     printable;
      logic     need_scroll;
      logic     ptr_copy_end;
      logic     ptr_fill_end;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/txcon_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module txcon_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/txcon_ctrl.sv =====
// Controller state machine for the text console engine. It sequences each
// operation and drives the datapath commands. Depends on txcon_pkg.
`timescale 1ns / 1ps
`default_nettype none

module txcon_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire txcon_pkg::dp_status_type status,
   output      txcon_pkg::ctrl_cmd_type  cmd
);

   txcon_pkg::state_type state_ff;
   txcon_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= txcon_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_src = txcon_pkg::RD_REQ;
      cmd.wr_src = txcon_pkg::WR_PUT;
      case (state_ff)
         txcon_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = txcon_pkg::ST_DECODE;
            end
         end
         txcon_pkg::ST_DECODE: begin
            case (status.func)
               txcon_pkg::FUNC_PUT: begin
                  cmd.put_step = 1'b1;
                  cmd.wr_en    = status.printable;
                  cmd.wr_src   = txcon_pkg::WR_PUT;
                  if (status.need_scroll) begin
                     cmd.ptr_zero = 1'b1;
                     state_in     = txcon_pkg::ST_SCROLL_RD;
                  end else begin
                     state_in = txcon_pkg::ST_RESPOND;
                  end
               end
               txcon_pkg::FUNC_CLEAR: begin
                  cmd.home     = 1'b1;
                  cmd.ptr_zero = 1'b1;
                  state_in     = txcon_pkg::ST_FILL;
               end
               txcon_pkg::FUNC_SET: begin
                  cmd.set_cursor = 1'b1;
                  state_in       = txcon_pkg::ST_RESPOND;
               end
               default: begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_src = txcon_pkg::RD_REQ;
                  state_in   = txcon_pkg::ST_READ_WAIT;
               end
            endcase
         end
         txcon_pkg::ST_READ_WAIT: begin
            cmd.respond = 1'b1;
            state_in    = txcon_pkg::ST_IDLE;
         end
         txcon_pkg::ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = txcon_pkg::ST_IDLE;
         end
         // Scroll: fetch the cell one row below, then store it one row up.
         txcon_pkg::ST_SCROLL_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = txcon_pkg::RD_SCROLL;
            state_in   = txcon_pkg::ST_SCROLL_WR;
         end
         txcon_pkg::ST_SCROLL_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = txcon_pkg::WR_COPY;
            cmd.ptr_inc = 1'b1;
            if (status.ptr_copy_end) begin
               state_in = txcon_pkg::ST_FILL;
            end else begin
               state_in = txcon_pkg::ST_SCROLL_RD;
            end
         end
         // Blank fill, used for the bottom row after a scroll and for clear.
         txcon_pkg::ST_FILL: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = txcon_pkg::WR_BLANK;
            cmd.ptr_inc = 1'b1;
            if (status.ptr_fill_end) begin
               cmd.respond = 1'b1;
               state_in    = txcon_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = txcon_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != txcon_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/txcon_dp.sv =====
// Datapath for the text console engine: request latch, cursor, attribute
// register, cell pointer, screen memory and response register.
// Depends on txcon_pkg and txcon_ram.
`timescale 1ns / 1ps
`default_nettype none

module txcon_dp #(
   parameter int COLUMNS = txcon_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = txcon_pkg::ROWS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire txcon_pkg::ctrl_cmd_type cmd,
   output      txcon_pkg::dp_status_type status,
   input  wire txcon_pkg::req_type      req_payload,
   input  wire logic                    csr_write_enable,
   input  wire logic [7:0]              csr_write_data,
   output      logic                    rsp_valid,
   output      txcon_pkg::rsp_type      rsp_payload
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   txcon_pkg::req_type req_ff;
   logic [6:0]         cur_col_ff;
   logic [6:0]         cur_col_in;
   logic [4:0]         cur_row_ff;
   logic [4:0]         cur_row_in;
   logic               scrolled_ff;
   logic [7:0]         attr_ff;
   logic [AW-1:0]      ptr_ff;
   logic               rsp_valid_ff;
   txcon_pkg::rsp_type rsp_payload_ff;
   txcon_pkg::rsp_type rsp_payload_in;

   logic [7:0]    col_step;
   logic [5:0]    row_step;
   logic          printable;
   logic          need_scroll;
   logic          addr_ok;
   logic [AW-1:0] cur_index;
   logic [15:0]   blank_cell;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [15:0]   ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [15:0]   ram_rd_data;

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
   end

   // Attribute register.
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= txcon_pkg::ATTR_RESET;
      end else if (csr_write_enable) begin
         attr_ff <= csr_write_data;
      end
   end

   // Cursor motion for put-char, including wrap past the last column.
   always_comb begin
      col_step  = {1'b0, cur_col_ff};
      row_step  = {1'b0, cur_row_ff};
      printable = 1'b0;
      case (req_ff.char_code)
         txcon_pkg::CH_BS: begin
            if (cur_col_ff != '0) begin
               col_step = col_step - 8'd1;
            end
         end
         txcon_pkg::CH_TAB: begin
            col_step = (col_step + 8'd8) & 8'hF8;
         end
         txcon_pkg::CH_CR: begin
            col_step = '0;
         end
         txcon_pkg::CH_LF: begin
            col_step = '0;
            row_step = row_step + 6'd1;
         end
         default: begin
            if ((req_ff.char_code >= txcon_pkg::CH_SPACE)
                  && (req_ff.char_code <= txcon_pkg::CH_LAST)) begin
               printable = 1'b1;
               col_step  = col_step + 8'd1;
            end
         end
      endcase
      if (32'(col_step) >= COLUMNS) begin
         col_step = '0;
         row_step = row_step + 6'd1;
      end
      need_scroll = (32'(row_step) >= ROWS);
   end

   // Next cursor value.
   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (cmd.home) begin
         cur_col_in = '0;
         cur_row_in = '0;
      end else if (cmd.set_cursor) begin
         cur_col_in = (32'(req_ff.set_col) > COLUMNS - 1) ? 7'(COLUMNS - 1)
                                                          : req_ff.set_col;
         cur_row_in = (32'(req_ff.set_row) > ROWS - 1) ? 5'(ROWS - 1)
                                                       : req_ff.set_row;
      end else if (cmd.put_step) begin
         cur_col_in = col_step[6:0];
         cur_row_in = need_scroll ? 5'(ROWS - 1) : row_step[4:0];
      end
   end

   // Cursor and scroll flag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         scrolled_ff <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         if (cmd.load) begin
            scrolled_ff <= 1'b0;
         end else if (cmd.put_step && need_scroll) begin
            scrolled_ff <= 1'b1;
         end
      end
   end

   // Cell pointer for scroll and fill sweeps.
   always_ff @(posedge clock) begin
      if (cmd.ptr_zero) begin
         ptr_ff <= '0;
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + AW'(1);
      end
   end

   assign cur_index  = AW'(32'(cur_row_ff) * COLUMNS + 32'(cur_col_ff));
   assign addr_ok    = (32'(req_ff.read_address) < CELLS);
   assign blank_cell = {attr_ff, txcon_pkg::CH_SPACE};

   // Screen memory address and data selection.
   always_comb begin
      ram_rd_en   = cmd.rd_en && ((cmd.rd_src != txcon_pkg::RD_REQ) || addr_ok);
      ram_rd_addr = (cmd.rd_src == txcon_pkg::RD_REQ) ? AW'(req_ff.read_address)
                                                      : ptr_ff + AW'(COLUMNS);
      ram_wr_en   = cmd.wr_en;
      case (cmd.wr_src)
         txcon_pkg::WR_PUT: begin
            ram_wr_addr = cur_index;
            ram_wr_data = {attr_ff, req_ff.char_code};
         end
         txcon_pkg::WR_COPY: begin
            ram_wr_addr = ptr_ff;
            ram_wr_data = ram_rd_data;
         end
         default: begin
            ram_wr_addr = ptr_ff;
            ram_wr_data = blank_cell;
         end
      endcase
   end

   txcon_ram #(
      .WIDTH (16),
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Response beat contents.
   always_comb begin
      rsp_payload_in.cursor_location = 11'(cur_index);
      rsp_payload_in.read_data       =
         ((req_ff.func == txcon_pkg::FUNC_READ) && addr_ok) ? ram_rd_data : 16'd0;
      rsp_payload_in.scrolled        = scrolled_ff;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // Status toward the controller.
   always_comb begin
      status.func         = req_ff.func;
      status.printable    = printable;
      status.need_scroll  = need_scroll;
      status.ptr_copy_end = (ptr_ff == AW'(CELLS - COLUMNS - 1));
      status.ptr_fill_end = (ptr_ff == AW'(CELLS - 1));
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== sv/text_console_char_engine.sv =====
// Top level of the text console character engine.
// Depends on txcon_pkg, txcon_ctrl, txcon_dp and txcon_ram.
// A request beat is taken when start is high and busy is low. Each request
// gives exactly one response beat, shown for one cycle with rsp_valid high;
// the receiver cannot stall it. Set cursor and put without scroll go from
// decode to the respond state; read goes from decode to a read-wait state
// that gives the response. Clear blanks every cell in turn; a put that
// scrolls copies each cell one row up, then blanks the bottom row. The
// long cases are set by the screen memory sweeps, one cell per read
// and one per write. busy falls with the response strobe, so the next
// request may be taken in that cycle. Screen cells hold nothing defined
// until the first clear. The attribute register may be written at any time
// the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_engine #(
   parameter int COLUMNS = txcon_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = txcon_pkg::ROWS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire txcon_pkg::req_type req_payload,
   output      logic               rsp_valid,
   output      txcon_pkg::rsp_type rsp_payload,
   input  wire logic               csr_write_enable,
   input  wire logic [7:0]         csr_write_data
);

   txcon_pkg::ctrl_cmd_type  cmd;
   txcon_pkg::dp_status_type status;

   // Operation sequencer.
   txcon_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Cursor, screen memory and response register.
   txcon_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload)
   );

endmodule

`default_nettype wire
